// File: src/assert_macros.svh
// Assertion macros used by the checker file.
// Every macro samples on the rising clock and is muted while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SWSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication.
`define SWSU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

// File: src/swsu_pkg.sv
// Package for the sliding window sender: item structs, codes, register defaults.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package swsu_pkg;

    // Window geometry (slot index = sequence number modulo WINDOW_MAX, a power of two)
    localparam int WINDOW_MAX = 16;
    localparam int SLOT_BITS  = $clog2(WINDOW_MAX);
    localparam int WCNT_BITS  = $clog2(WINDOW_MAX + 1);

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_PACKETS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILE_SIZE     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PACKET_SIZE   = 2'd3;

    // Register reset values
    localparam logic [4:0]  RST_WINDOW_SIZE   = 5'd5;
    localparam logic [31:0] RST_TOTAL_PACKETS = 32'd2;
    localparam logic [31:0] RST_FILE_SIZE     = 32'd0;
    localparam logic [15:0] RST_PACKET_SIZE   = 16'd2048;

    // Input actions
    localparam logic ACT_ACK  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_SEND   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Packet types
    localparam logic [1:0] PKT_NONE = 2'd0;
    localparam logic [1:0] PKT_DATA = 2'd1;
    localparam logic [1:0] PKT_NAME = 2'd2;
    localparam logic [1:0] PKT_END  = 2'd3;

    typedef struct packed {
        logic        action;
        logic [31:0] ack_seq;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [31:0] seq;
        logic [1:0]  pkt_type;
        logic [31:0] byte_offset;
        logic [15:0] payload_len;
        logic [31:0] window_begin;
        logic        done_res;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [4:0]  window_size;
        logic [31:0] total_packets;
        logic [31:0] file_size;
        logic [15:0] packet_size;
    } t_cfg;

    // Access to the ack mark memory
    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] waddr;
        logic                 wdata;
        logic [SLOT_BITS-1:0] raddr;
    } t_mark_req;

endpackage

// File: src/swsu_mark_ram.sv
// Ack mark memory: one bit per window slot, one write and one registered read per cycle.
// Per-entry valid bits make every slot read as cleared after reset. Uses swsu_pkg.
`timescale 1ns / 1ps

module swsu_mark_ram (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swsu_pkg::t_mark_req i_req,
    output logic                o_rd_mark
);
    import swsu_pkg::*;

    logic [WINDOW_MAX-1:0] r_mark;
    logic [WINDOW_MAX-1:0] r_vld;
    logic                  r_rd;

    // Storage array and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mark[i_req.waddr] <= i_req.wdata;
        end
        r_rd <= r_vld[i_req.raddr] & r_mark[i_req.raddr];
    end

    // Valid bits: cleared by reset, set on the first write of a slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    assign o_rd_mark = r_rd;

endmodule

// File: src/swsu_out_reg.sv
// Output register of the result channel: holds one result item under stall.
// Uses swsu_pkg for the result item type.
`timescale 1ns / 1ps

module swsu_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  swsu_pkg::t_out i_item,
    output logic           o_ready,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output swsu_pkg::t_out o_out
);
    import swsu_pkg::*;

    logic r_valid;
    t_out r_item;

    // Free when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_item;

endmodule

// File: src/swsu_ctrl.sv
// Sequencer of the sender window: ack marking and sliding, tick scan and result build.
// Reads and rewrites the ack mark memory; uses swsu_pkg.
`timescale 1ns / 1ps

module swsu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swsu_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  swsu_pkg::t_in       i_in,
    output swsu_pkg::t_mark_req o_req,
    input  logic                i_rd_mark,
    input  logic                i_out_ready,
    output logic                o_load,
    output swsu_pkg::t_out      o_item
);
    import swsu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_SLIDE_RD,
        ST_SLIDE_CHK,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_TICK_EMIT,
        ST_STATUS
    } t_state;

    t_state               r_state;
    logic [31:0]          r_ws;
    logic [31:0]          r_ack_seq;
    logic [WCNT_BITS-1:0] r_idx;
    logic [32:0]          r_s;
    logic [47:0]          r_prod;

    logic [WCNT_BITS-1:0] w_eff;
    logic [32:0]          scan_s;
    logic                 scan_end;
    logic [31:0]          ack_rel;
    logic                 ack_ok;
    logic                 slide_go;
    logic [31:0]          ws_inc;
    logic                 done;
    logic [31:0]          off;
    logic [31:0]          rem;

    // Effective window: zero acts as one, capped at WINDOW_MAX
    always_comb begin
        if (i_cfg.window_size == '0) begin
            w_eff = WCNT_BITS'(1);
        end else if ({{(32-5){1'b0}}, i_cfg.window_size} > 32'(WINDOW_MAX)) begin
            w_eff = WCNT_BITS'(WINDOW_MAX);
        end else begin
            w_eff = WCNT_BITS'(i_cfg.window_size);
        end
    end

    // Ack lies in the window and in the transfer
    assign ack_rel = r_ack_seq - r_ws;
    assign ack_ok  = (r_ack_seq >= r_ws) && (ack_rel < 32'(w_eff))
                     && (r_ack_seq < i_cfg.total_packets);

    // Front slot is acked and the transfer is not finished
    assign slide_go = i_rd_mark && (r_ws < i_cfg.total_packets);
    assign ws_inc   = r_ws + 32'd1;
    assign done     = r_ws >= i_cfg.total_packets;

    // Next slot of the tick scan
    assign scan_s   = {1'b0, r_ws} + 33'(r_idx);
    assign scan_end = (r_idx >= w_eff) || (scan_s >= {1'b0, i_cfg.total_packets});

    // Memory access per state
    always_comb begin
        o_req.we    = 1'b0;
        o_req.waddr = r_ws[SLOT_BITS-1:0];
        o_req.wdata = 1'b0;
        o_req.raddr = r_ws[SLOT_BITS-1:0];
        unique case (r_state)
            ST_ACK: begin
                o_req.we    = ack_ok;
                o_req.waddr = r_ack_seq[SLOT_BITS-1:0];
                o_req.wdata = 1'b1;
            end
            ST_SLIDE_CHK: begin
                o_req.we    = slide_go;
                o_req.raddr = ws_inc[SLOT_BITS-1:0];
            end
            ST_TICK_RD: begin
                o_req.raddr = scan_s[SLOT_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    // Offset clamp and payload length of a send order
    assign off = (r_prod > {16'd0, i_cfg.file_size}) ? i_cfg.file_size : r_prod[31:0];
    assign rem = i_cfg.file_size - off;

    // Result item build
    always_comb begin
        o_item              = '0;
        o_item.window_begin = r_ws;
        o_item.done_res     = done;
        o_load              = 1'b0;
        if (r_state == ST_STATUS) begin
            o_item.kind = KIND_STATUS;
            o_item.last = 1'b1;
            o_load      = i_out_ready;
        end else begin
            o_item.kind = KIND_SEND;
            o_item.seq  = r_s[31:0];
            o_load      = (r_state == ST_TICK_EMIT) && i_out_ready;
            if (r_s == '0) begin
                o_item.pkt_type = PKT_NAME;
            end else if ((r_s + 33'd1) == {1'b0, i_cfg.total_packets}) begin
                o_item.pkt_type    = PKT_END;
                o_item.byte_offset = off;
            end else begin
                o_item.pkt_type    = PKT_DATA;
                o_item.byte_offset = off;
                o_item.payload_len = (rem < {16'd0, i_cfg.packet_size})
                                     ? rem[15:0] : i_cfg.packet_size;
            end
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // State and registers of the sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ws    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_ack_seq <= i_in.ack_seq;
                        r_idx     <= '0;
                        r_state   <= (i_in.action == ACT_TICK) ? ST_TICK_RD : ST_ACK;
                    end
                end
                ST_ACK: begin
                    r_state <= ack_ok ? ST_SLIDE_RD : ST_IDLE;
                end
                ST_SLIDE_RD: begin
                    r_state <= ST_SLIDE_CHK;
                end
                ST_SLIDE_CHK: begin
                    if (slide_go) begin
                        r_ws <= ws_inc;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_TICK_RD: begin
                    r_s     <= scan_s;
                    r_state <= scan_end ? ST_STATUS : ST_TICK_CHK;
                end
                ST_TICK_CHK: begin
                    r_prod <= {16'd0, r_s[31:0] - 32'd1} * {32'd0, i_cfg.packet_size};
                    if (i_rd_mark) begin
                        r_idx   <= r_idx + WCNT_BITS'(1);
                        r_state <= ST_TICK_RD;
                    end else begin
                        r_state <= ST_TICK_EMIT;
                    end
                end
                ST_TICK_EMIT: begin
                    if (i_out_ready) begin
                        r_idx   <= r_idx + WCNT_BITS'(1);
                        r_state <= ST_TICK_RD;
                    end
                end
                ST_STATUS: begin
                    if (i_out_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/sliding_window_sender_unit.sv
// Sliding window sender, selective-repeat: top level with configuration registers.
// An ack out of window or transfer is ignored; else it is marked and the window slides.
// A tick sends an order per unacked window slot, then the status, waiting on output stalls;
// each slot costs one registered read of the mark memory, send orders one multiply stage.
// Synchronous active-low reset clears window start, ack marks and registers to defaults.
// Builds on swsu_pkg, swsu_mark_ram, swsu_out_reg and swsu_ctrl.
`timescale 1ns / 1ps

module sliding_window_sender_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swsu_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [31:0]                         i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  swsu_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output swsu_pkg::t_out                      o_out
);
    import swsu_pkg::*;

    t_cfg      r_cfg;
    t_mark_req mark_req;
    logic      rd_mark;
    logic      out_ready;
    logic      load;
    t_out      item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_size   <= RST_WINDOW_SIZE;
            r_cfg.total_packets <= RST_TOTAL_PACKETS;
            r_cfg.file_size     <= RST_FILE_SIZE;
            r_cfg.packet_size   <= RST_PACKET_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_SIZE:   r_cfg.window_size   <= i_cfg_wdata[4:0];
                CFG_TOTAL_PACKETS: r_cfg.total_packets <= i_cfg_wdata;
                CFG_FILE_SIZE:     r_cfg.file_size     <= i_cfg_wdata;
                CFG_PACKET_SIZE:   r_cfg.packet_size   <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    swsu_mark_ram u_mark_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mark_req),
        .o_rd_mark (rd_mark)
    );

    swsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_req       (mark_req),
        .i_rd_mark   (rd_mark),
        .i_out_ready (out_ready),
        .o_load      (load),
        .o_item      (item)
    );

    swsu_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_item      (item),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// File: src/swsu_checker.sv
// Port-level checker of the sliding window sender, bound to the top level.
// Uses swsu_pkg and the macros of assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swsu_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input swsu_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input swsu_pkg::t_out o_out
);
    import swsu_pkg::*;

    // A stalled result holds
    `SWSU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

    // One item at a time: busy right after an accept
    `SWSU_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // An ack never creates a result
    `SWSU_ASSERT_NXT(a_ack_silent, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in.action == ACT_ACK) && !o_out_valid, !o_out_valid)

    // The final result of a tick is the status report and only it
    `SWSU_ASSERT_IMP(a_last_is_status, i_clk, i_rst_n, o_out_valid, o_out.last == (o_out.kind == KIND_STATUS))

endmodule

bind sliding_window_sender_unit swsu_checker u_swsu_checker (.*);

// File: bench/tb_sliding_window_sender_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for sliding_window_sender_unit: directed corner cases, then random
// ack/tick traffic under several register settings, checked against an in-bench window model.
// Depends on swsu_pkg and the sliding_window_sender_unit RTL only.

module tb_sliding_window_sender_unit;
    import swsu_pkg::*;

    localparam int LIMIT_CYCLES    = 500000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 34;
    localparam int IDLE_PERCENT    = 29;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = CFG_WINDOW_SIZE;
    logic [31:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    sliding_window_sender_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    // Shadow of the configuration registers
    logic [4:0]  reg_window      = RST_WINDOW_SIZE;
    logic [31:0] reg_total       = RST_TOTAL_PACKETS;
    logic [31:0] reg_file_size   = RST_FILE_SIZE;
    logic [15:0] reg_packet_size = RST_PACKET_SIZE;

    // Shadow of the window state
    logic [31:0]           win_start = '0;
    logic [WINDOW_MAX-1:0] ack_slots = '0;

    t_in  sender_events[$];
    t_out expected_sends[$];

    logic steady_flow = 1'b0;
    logic in_taken = 1'b0;
    int   mismatch_count = 0;
    int   results_checked = 0;
    int   acks_taken = 0;
    int   ticks_taken = 0;
    int   settings_used = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Window size as the block uses it: 0 acts as 1, capped at WINDOW_MAX
    function automatic logic [63:0] active_window();
        logic [63:0] w;
        w = {59'd0, reg_window};
        if (w == 0) w = 1;
        else if (w > WINDOW_MAX) w = WINDOW_MAX;
        return w;
    endfunction

    // Apply one accepted item to the shadow window; a tick queues its send orders and status
    task automatic advance_window(input t_in item);
        logic [63:0] ws, total, w, a, s, off, rem;
        t_out r;
        ws    = {32'd0, win_start};
        total = {32'd0, reg_total};
        w     = active_window();
        if (item.action == ACT_ACK) begin
            acks_taken++;
            a = {32'd0, item.ack_seq};
            if (a >= ws && a < ws + w && a < total) begin
                ack_slots[a[SLOT_BITS-1:0]] = 1'b1;
                // slide past acked packets at the front
                while (ws < total && ack_slots[ws[SLOT_BITS-1:0]]) begin
                    ack_slots[ws[SLOT_BITS-1:0]] = 1'b0;
                    ws++;
                end
                win_start = ws[31:0];
            end
        end else begin
            ticks_taken++;
            for (s = ws; s < ws + w && s < total; s++) begin
                if (!ack_slots[s[SLOT_BITS-1:0]]) begin
                    r = '0;
                    r.kind = KIND_SEND;
                    r.seq  = s[31:0];
                    if (s == 0) begin
                        r.pkt_type = PKT_NAME;
                    end else begin
                        off = (s - 1) * reg_packet_size;
                        if (off > reg_file_size) off = reg_file_size;
                        r.byte_offset = off[31:0];
                        if (s == total - 1) begin
                            r.pkt_type = PKT_END;
                        end else begin
                            rem = reg_file_size - off;
                            r.pkt_type = PKT_DATA;
                            r.payload_len = (rem < reg_packet_size) ? rem[15:0] : reg_packet_size;
                        end
                    end
                    r.window_begin = win_start;
                    r.done_res = (ws >= total);
                    expected_sends.push_back(r);
                end
            end
            r = '0;
            r.kind = KIND_STATUS;
            r.window_begin = win_start;
            r.done_res = (ws >= total);
            r.last = 1'b1;
            expected_sends.push_back(r);
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    // Input driver: holds a stalled item, otherwise takes the next one or idles
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold payload until accepted
        end else if (sender_events.size() != 0
                     && (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            i_in       <= sender_events.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result-side back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Monitor: check results in order, feed accepted items to the shadow model
    always @(posedge i_clk) begin
        t_out want;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_sends.size() == 0) begin
                $error("unexpected result: kind %0d seq 0x%0h", o_out.kind, o_out.seq);
                mismatch_count++;
            end else begin
                want = expected_sends.pop_front();
                check_field("kind",         want.kind,         o_out.kind);
                check_field("seq",          want.seq,          o_out.seq);
                check_field("pkt_type",     want.pkt_type,     o_out.pkt_type);
                check_field("byte_offset",  want.byte_offset,  o_out.byte_offset);
                check_field("payload_len",  want.payload_len,  o_out.payload_len);
                check_field("window_begin", want.window_begin, o_out.window_begin);
                check_field("done_res",     want.done_res,     o_out.done_res);
                check_field("last",         want.last,         o_out.last);
                results_checked++;
            end
        end
        if (in_taken) advance_window(i_in);
    end

    task automatic queue_ack(input logic [31:0] seq);
        t_in it;
        it.action  = ACT_ACK;
        it.ack_seq = seq;
        sender_events.push_back(it);
    endtask

    // ack_seq is don't-care on a tick, so it carries random bits
    task automatic queue_tick();
        t_in it;
        it.action  = ACT_TICK;
        it.ack_seq = $urandom;
        sender_events.push_back(it);
    endtask

    // Every queued item has been accepted (and predicted)
    task automatic wait_inputs_taken();
        while (sender_events.size() != 0 || i_in_valid) @(posedge i_clk);
    endtask

    // Block idle: all items in, all results out, plus room for a trailing ack to finish
    task automatic drain_and_settle();
        wait_inputs_taken();
        do @(negedge i_clk); while (expected_sends.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_WINDOW_SIZE:   reg_window      = data[4:0];
            CFG_TOTAL_PACKETS: reg_total       = data;
            CFG_FILE_SIZE:     reg_file_size   = data;
            CFG_PACKET_SIZE:   reg_packet_size = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_transfer(input logic [31:0] window_word, input logic [31:0] total,
                                    input logic [31:0] file_bytes, input logic [31:0] psize_word);
        write_register(CFG_WINDOW_SIZE,   window_word);
        write_register(CFG_TOTAL_PACKETS, total);
        write_register(CFG_FILE_SIZE,     file_bytes);
        write_register(CFG_PACKET_SIZE,   psize_word);
        settings_used++;
        @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        logic [31:0] base, wword, pword, total, file_bytes;
        int unsigned span, w, n, roll, counted;
        int phase;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short transfers from window start 0: zero packets, then name packet only
        write_register(CFG_TOTAL_PACKETS, 32'd0);
        @(posedge i_clk);
        queue_tick();
        drain_and_settle();
        write_register(CFG_TOTAL_PACKETS, 32'd1);
        @(posedge i_clk);
        queue_tick();
        drain_and_settle();

        // Reset-like settings: name + end, acks out of order and past the end
        write_register(CFG_TOTAL_PACKETS, RST_TOTAL_PACKETS);
        @(posedge i_clk);
        queue_tick();
        queue_ack(32'd1);
        queue_tick();
        queue_ack(32'd5);
        queue_ack(32'd0);
        queue_tick();
        drain_and_settle();

        // Window 0 acts as 1; short last data packet, data past end of file, end packet
        base = win_start;
        program_transfer(32'd0, base + 4, 32'd5000, 32'd2048);
        queue_tick();
        queue_ack(base + 1);
        queue_ack(base);
        queue_tick();
        queue_ack(32'hFFFF_FFFF);
        queue_ack(base - 1);
        queue_tick();
        queue_ack(base + 1);
        queue_tick();
        queue_ack(base + 2);
        queue_tick();
        drain_and_settle();

        // Extremes: oversize window, widest total, file and packet size, masked upper bits
        base = win_start;
        program_transfer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hABCD_FFFF);
        queue_tick();
        queue_ack(base + 15);
        queue_tick();
        queue_ack(base);
        queue_tick();

        // Random phases: mostly in-window acks followed by a tick, some noise
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_and_settle();
            base  = win_start;
            span  = $urandom_range(4, 48);
            wword = ($urandom & 32'hFFFF_FFE0) | $urandom_range(0, 31);
            pword = ($urandom & 32'hFFFF_0000) | $urandom_range(1, 4096);
            case (phase)
                0: wword = 32'd1;
                1: wword = 32'd16;
                2: begin
                    wword = ($urandom & 32'hFFFF_FFE0) | 32'd31;
                    pword = ($urandom & 32'hFFFF_0000) | 32'd1;
                end
                3: pword = 32'h0000_FFFF;
                default: ;
            endcase
            total = base + span;
            if (phase == 4) total = $urandom | 32'h8000_0000;
            if (phase == 5) total = 32'hFFFF_FFFF;
            if (phase == 6) total = base + 2;
            file_bytes = $urandom_range(0, 32'(pword[15:0]) * span);
            if (phase == 1) file_bytes = 32'd0;
            if (phase == 5) file_bytes = 32'hFFFF_FFFF;
            steady_flow = (phase == 3);
            program_transfer(wword, total, file_bytes, pword);

            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                w    = 32'(active_window());
                if (roll < 65) begin
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++) begin
                        if (k == 0 && $urandom_range(0, 1)) queue_ack(win_start);
                        else queue_ack(win_start + $urandom_range(0, w - 1));
                    end
                    queue_tick();
                    counted += n + 1;
                end else if (roll < 85) begin
                    // acks the block must ignore
                    case ($urandom_range(0, 2))
                        0: queue_ack($urandom);
                        1: queue_ack(win_start + w + $urandom_range(0, 20));
                        default: queue_ack(win_start - 1 - $urandom_range(0, 3));
                    endcase
                end else begin
                    queue_tick();
                    counted++;
                end
                wait_inputs_taken();
            end
        end
        steady_flow = 1'b0;
        drain_and_settle();

        $display("covered %0d acks and %0d ticks over %0d register settings",
                 acks_taken, ticks_taken, settings_used);
        $display("compared %0d results; window start finished at %0d",
                 results_checked, win_start);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still expected",
                 LIMIT_CYCLES, expected_sends.size());
        $display("status: fail");
        $finish;
    end

endmodule
